// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the NTC linearizer.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ntcol_pkg.sv =====
// Package of the NTC linearizer: field widths, register indexes, the NTC table
// and the microcode program of the sequencer. No dependencies.
`default_nettype none

package ntcol_pkg;

   // Field widths.
   localparam int ADC_W    = 10;
   localparam int CNT_W    = 5;
   localparam int BASE_W   = 13;
   localparam int MILLI_W  = 18;
   localparam int CHAR_W   = 6;
   localparam int SUM_W    = 14;
   localparam int TAKEN_W  = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   // Default parameter values.
   localparam int DEF_TABLE_ENTRIES = 110;
   localparam int DEF_MAX_SAMPLES   = 16;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_BASE   = 1'd1;

   // Register reset values.
   localparam logic [CNT_W-1:0]         SAMPLE_COUNT_RST = 5'd10;
   localparam logic signed [BASE_W-1:0] TABLE_BASE_RST   = -13'sd1000;

   // Arithmetic constants.
   localparam int DIV_W       = 17;   // widest dividend: (v - lo) * 100
   localparam int DEN_W       = 10;   // widest divisor: a segment width
   localparam int ITER_W      = 5;
   localparam int CENTI_W     = 15;
   localparam int MAG_W       = 14;
   localparam int WIDE_W      = 20;
   localparam int DIGITS      = 4;    // decimal digits of |centi|
   localparam int CENTI_MAX   = 9999;
   localparam int CENTI_PER_DEG = 100;
   localparam int RECIP_TEN   = 52429; // ceil(2^19 / 10), exact for 16-bit values
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = 30;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'h30;
   localparam logic [CHAR_W-1:0] ASCII_PLUS  = 6'd43;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

   // NTC table: ADC code at each whole degree, rising.
   localparam int STORED_POINTS = 110;
   localparam int PT_IDX_W      = $clog2(STORED_POINTS);

   localparam logic [ADC_W-1:0] NTC_POINTS [STORED_POINTS] = '{
      10'd176, 10'd184, 10'd192, 10'd200, 10'd208, 10'd216, 10'd224, 10'd233, 10'd242, 10'd250,
      10'd260, 10'd269, 10'd278, 10'd287, 10'd297, 10'd307, 10'd317, 10'd326, 10'd336, 10'd347,
      10'd357, 10'd367, 10'd377, 10'd387, 10'd398, 10'd408, 10'd419, 10'd429, 10'd439, 10'd450,
      10'd460, 10'd470, 10'd481, 10'd491, 10'd501, 10'd511, 10'd521, 10'd531, 10'd541, 10'd551,
      10'd561, 10'd570, 10'd580, 10'd589, 10'd599, 10'd608, 10'd617, 10'd626, 10'd635, 10'd643,
      10'd652, 10'd660, 10'd668, 10'd676, 10'd684, 10'd692, 10'd700, 10'd708, 10'd715, 10'd722,
      10'd729, 10'd736, 10'd743, 10'd750, 10'd756, 10'd763, 10'd769, 10'd775, 10'd781, 10'd787,
      10'd792, 10'd798, 10'd804, 10'd809, 10'd814, 10'd819, 10'd824, 10'd829, 10'd834, 10'd838,
      10'd843, 10'd847, 10'd851, 10'd855, 10'd859, 10'd863, 10'd867, 10'd871, 10'd875, 10'd878,
      10'd882, 10'd885, 10'd888, 10'd891, 10'd895, 10'd898, 10'd901, 10'd903, 10'd906, 10'd909,
      10'd912, 10'd914, 10'd917, 10'd919, 10'd922, 10'd924, 10'd926, 10'd928, 10'd931, 10'd933
   };

   // Microcode: datapath operations.
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_DIV    = 3'd0;
   localparam logic [OP_W-1:0] OP_CLAMP  = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
   localparam logic [OP_W-1:0] OP_SEG    = 3'd3;
   localparam logic [OP_W-1:0] OP_CENTI  = 3'd4;
   localparam logic [OP_W-1:0] OP_ABS    = 3'd5;
   localparam logic [OP_W-1:0] OP_DIGIT  = 3'd6;
   localparam logic [OP_W-1:0] OP_EMIT   = 3'd7;

   // Microcode: sequencing conditions.
   localparam int COND_W = 2;
   localparam logic [COND_W-1:0] COND_NEXT   = 2'd0;
   localparam logic [COND_W-1:0] COND_ITER   = 2'd1;
   localparam logic [COND_W-1:0] COND_SEARCH = 2'd2;
   localparam logic [COND_W-1:0] COND_EMIT   = 2'd3;

   // Microcode: program steps.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] S_DIV_MEAN = 4'd0;
   localparam logic [STEP_W-1:0] S_CLAMP    = 4'd1;
   localparam logic [STEP_W-1:0] S_SEARCH   = 4'd2;
   localparam logic [STEP_W-1:0] S_SEG      = 4'd3;
   localparam logic [STEP_W-1:0] S_DIV_FRAC = 4'd4;
   localparam logic [STEP_W-1:0] S_CENTI    = 4'd5;
   localparam logic [STEP_W-1:0] S_ABS      = 4'd6;
   localparam logic [STEP_W-1:0] S_DIGIT    = 4'd7;
   localparam logic [STEP_W-1:0] S_EMIT     = 4'd8;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_fetch(input logic [STEP_W-1:0] step);
      ucode_type uc;
      case (step)
         S_DIV_MEAN: uc = '{op: OP_DIV,    cond: COND_ITER,   target: S_DIV_MEAN};
         S_CLAMP:    uc = '{op: OP_CLAMP,  cond: COND_NEXT,   target: S_CLAMP};
         S_SEARCH:   uc = '{op: OP_SEARCH, cond: COND_SEARCH, target: S_SEARCH};
         S_SEG:      uc = '{op: OP_SEG,    cond: COND_NEXT,   target: S_SEG};
         S_DIV_FRAC: uc = '{op: OP_DIV,    cond: COND_ITER,   target: S_DIV_FRAC};
         S_CENTI:    uc = '{op: OP_CENTI,  cond: COND_NEXT,   target: S_CENTI};
         S_ABS:      uc = '{op: OP_ABS,    cond: COND_NEXT,   target: S_ABS};
         S_DIGIT:    uc = '{op: OP_DIGIT,  cond: COND_ITER,   target: S_DIGIT};
         S_EMIT:     uc = '{op: OP_EMIT,   cond: COND_EMIT,   target: S_EMIT};
         default:    uc = '{op: OP_EMIT,   cond: COND_EMIT,   target: S_EMIT};
      endcase
      return uc;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ntc_oversample_linearizer.sv =====
// Top level of the NTC oversampling linearizer: accumulator, microcoded
// sequencer and its datapath. Depends on ntcol_pkg and assert_macros.svh.
//
// Usage. ADC words enter on the req_ channel (req_valid, req_stall,
// req_adc_sample) and are taken at an edge with req_valid high and req_stall
// low. Each word is added to a running sum in the cycle it is taken. When the
// configured number of words has been summed, the block drops into its
// sequencer program and raises req_stall until the program ends; words that
// do not complete an average leave req_stall low.
// A completing word yields one result word on the rsp_ channel. Its program
// runs the serial mean division, the table walk one table point a cycle
// (1 to 110 steps), the serial fraction division, 4 digit steps and 5 single
// steps; both divisions share one divider that makes one quotient bit a cycle.
// Results sit in an output register; the block takes new words while a result
// waits, and only the final emit step holds while rsp_stall keeps the
// previous result in place. Configuration (csr_ channel) is always ready and
// is meant to be written while the block is idle.
// Reset restores sample_count to 10 and table_base_centi to -1000, clears
// the sum and count of words taken, and empties the output register.
`default_nettype none

`include "assert_macros.svh"

module ntc_oversample_linearizer #(
   parameter int TABLE_ENTRIES = ntcol_pkg::DEF_TABLE_ENTRIES,
   parameter int MAX_SAMPLES   = ntcol_pkg::DEF_MAX_SAMPLES
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Input words.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [ntcol_pkg::ADC_W-1:0]        req_adc_sample,
   // Result words.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [ntcol_pkg::MILLI_W-1:0]    rsp_temperature_milli,
   output logic [ntcol_pkg::CHAR_W-1:0]            rsp_sign_char,
   output logic [ntcol_pkg::CHAR_W-1:0]            rsp_digit_ten_thousands,
   output logic [ntcol_pkg::CHAR_W-1:0]            rsp_digit_thousands,
   output logic [ntcol_pkg::CHAR_W-1:0]            rsp_digit_hundreds,
   output logic [ntcol_pkg::CHAR_W-1:0]            rsp_digit_tens,
   output logic [ntcol_pkg::CHAR_W-1:0]            rsp_digit_ones,
   output logic                                    rsp_out_of_table,
   // Configuration writes.
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ntcol_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ntcol_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ntcol_pkg::*;

   // Points actually used from the stored table, at least two.
   localparam int N_POINTS = (TABLE_ENTRIES > STORED_POINTS) ? STORED_POINTS :
                             ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
   localparam int LAST_PT  = N_POINTS - 1;
   localparam int KW       = $clog2(N_POINTS);
   localparam int CNTW     = $clog2(MAX_SAMPLES + 1);

   // Configuration registers.
   logic [CNT_W-1:0]         sample_count_ff, sample_count_in;
   logic signed [BASE_W-1:0] table_base_ff, table_base_in;

   // Accumulator.
   logic [SUM_W-1:0]   sample_sum_ff, sample_sum_in;
   logic [TAKEN_W-1:0] samples_taken_ff, samples_taken_in;

   // Sequencer.
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] pc_ff, pc_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   ucode_type         uc;

   // Datapath.
   logic [DEN_W-1:0]          div_rem_ff, div_rem_in;
   logic [DIV_W-1:0]          div_quo_ff, div_quo_in;
   logic [DEN_W-1:0]          div_den_ff, div_den_in;
   logic [ADC_W-1:0]          v_ff, v_in;
   logic                      flag_ff, flag_in;
   logic [KW-1:0]             k_ff, k_in;
   logic [KW-1:0]             seg_ff, seg_in;
   logic                      flat_ff, flat_in;
   logic signed [CENTI_W-1:0] centi_ff, centi_in;
   logic                      neg_ff, neg_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic [DIGITS*4-1:0]       dig_ff, dig_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [MILLI_W-1:0] milli_ff, milli_in;
   logic [CHAR_W-1:0]         sign_ff, sign_in;
   logic [DIGITS*4-1:0]       out_dig_ff, out_dig_in;
   logic                      out_flag_ff, out_flag_in;

   // Combinational helpers.
   logic [CNTW-1:0]         eff_count;
   logic [SUM_W-1:0]        sum_next;
   logic [TAKEN_W-1:0]      taken_next;
   logic                    req_take;
   logic                    out_busy;
   logic                    search_more;
   logic [DEN_W:0]          trial;
   logic                    trial_ge;
   logic [KW-1:0]           seg_c;
   logic [KW-1:0]           hi_idx;
   logic [ADC_W-1:0]        lo_pt, hi_pt;
   logic signed [WIDE_W-1:0] centi_wide;
   logic [PROD_W-1:0]       prod;
   logic [MAG_W-1:0]        quo_ten;
   logic [3:0]              digit;

   assign uc        = ucode_fetch(pc_ff);
   assign req_stall = busy_ff;
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && !busy_ff;
   assign out_busy  = rsp_valid_ff && rsp_stall;

   // A count of zero means one; anything above the parameter saturates.
   always_comb begin
      int c;
      c = int'(sample_count_ff);
      if (c < 1) begin
         c = 1;
      end else if (c > MAX_SAMPLES) begin
         c = MAX_SAMPLES;
      end
      eff_count = CNTW'(c);
   end

   assign sum_next   = sample_sum_ff + SUM_W'(req_adc_sample);
   assign taken_next = samples_taken_ff + 1'b1;

   // Table walk: stop at the first point not below v, or at the last point.
   assign search_more = (32'(k_ff) < LAST_PT) && (NTC_POINTS[PT_IDX_W'(k_ff)] < v_ff);

   // Restoring divider, one quotient bit per step.
   assign trial    = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign trial_ge = trial >= {1'b0, div_den_ff};

   // Segment below point k, or the first segment when k is zero.
   assign seg_c  = (k_ff == '0) ? '0 : k_ff - 1'b1;
   assign hi_idx = (k_ff == '0) ? KW'(1) : k_ff;
   assign lo_pt  = NTC_POINTS[PT_IDX_W'(seg_c)];
   assign hi_pt  = NTC_POINTS[PT_IDX_W'(hi_idx)];

   assign centi_wide = WIDE_W'(table_base_ff)
                     + $signed(WIDE_W'(seg_ff) * WIDE_W'(CENTI_PER_DEG))
                     + $signed(WIDE_W'(flat_ff ? '0 : div_quo_ff));

   // Divide by ten with a reciprocal multiply, then take the remainder.
   assign prod    = PROD_W'(mag_ff) * PROD_W'(RECIP_TEN);
   assign quo_ten = MAG_W'(prod >> RECIP_SHIFT);
   assign digit   = 4'(mag_ff - MAG_W'(quo_ten * MAG_W'(10)));

   always_comb begin
      sample_count_in  = sample_count_ff;
      table_base_in    = table_base_ff;
      sample_sum_in    = sample_sum_ff;
      samples_taken_in = samples_taken_ff;
      busy_in          = busy_ff;
      pc_in            = pc_ff;
      iter_in          = iter_ff;
      div_rem_in       = div_rem_ff;
      div_quo_in       = div_quo_ff;
      div_den_in       = div_den_ff;
      v_in             = v_ff;
      flag_in          = flag_ff;
      k_in             = k_ff;
      seg_in           = seg_ff;
      flat_in          = flat_ff;
      centi_in         = centi_ff;
      neg_in           = neg_ff;
      mag_in           = mag_ff;
      dig_in           = dig_ff;
      rsp_valid_in     = rsp_valid_ff;
      milli_in         = milli_ff;
      sign_in          = sign_ff;
      out_dig_in       = out_dig_ff;
      out_flag_in      = out_flag_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_in = csr_wdata[CNT_W-1:0];
            CSR_TABLE_BASE:   table_base_in   = $signed(csr_wdata[BASE_W-1:0]);
            default: ;
         endcase
      end

      // Accumulate; a completing word starts the program with the mean division.
      if (req_take) begin
         if (32'(taken_next) >= 32'(eff_count)) begin
            sample_sum_in    = '0;
            samples_taken_in = '0;
            busy_in          = 1'b1;
            pc_in            = S_DIV_MEAN;
            iter_in          = ITER_W'(DIV_W - 1);
            div_rem_in       = '0;
            div_quo_in       = DIV_W'(sum_next);
            div_den_in       = DEN_W'(eff_count);
         end else begin
            sample_sum_in    = sum_next;
            samples_taken_in = taken_next;
         end
      end

      if (busy_ff) begin
         case (uc.op)
            OP_DIV: begin
               div_rem_in = trial_ge ? DEN_W'(trial - {1'b0, div_den_ff}) : trial[DEN_W-1:0];
               div_quo_in = {div_quo_ff[DIV_W-2:0], trial_ge};
               iter_in    = iter_ff - 1'b1;
            end
            OP_CLAMP: begin
               k_in = '0;
               if (div_quo_ff < DIV_W'(NTC_POINTS[0])) begin
                  v_in    = NTC_POINTS[0];
                  flag_in = 1'b1;
               end else if (div_quo_ff > DIV_W'(NTC_POINTS[LAST_PT])) begin
                  v_in    = NTC_POINTS[LAST_PT];
                  flag_in = 1'b1;
               end else begin
                  v_in    = div_quo_ff[ADC_W-1:0];
                  flag_in = 1'b0;
               end
            end
            OP_SEARCH: begin
               if (search_more) begin
                  k_in = k_ff + 1'b1;
               end
            end
            OP_SEG: begin
               seg_in     = seg_c;
               flat_in    = (hi_pt == lo_pt);
               div_rem_in = '0;
               div_quo_in = DIV_W'(v_ff - lo_pt) * DIV_W'(CENTI_PER_DEG);
               div_den_in = hi_pt - lo_pt;
               iter_in    = ITER_W'(DIV_W - 1);
            end
            OP_CENTI: begin
               if (centi_wide > WIDE_W'(CENTI_MAX)) begin
                  centi_in = CENTI_W'(CENTI_MAX);
               end else if (centi_wide < -WIDE_W'(CENTI_MAX)) begin
                  centi_in = -CENTI_W'(CENTI_MAX);
               end else begin
                  centi_in = centi_wide[CENTI_W-1:0];
               end
            end
            OP_ABS: begin
               neg_in  = centi_ff < 0;
               mag_in  = (centi_ff < 0) ? MAG_W'(-centi_ff) : MAG_W'(centi_ff);
               iter_in = ITER_W'(DIGITS - 1);
            end
            OP_DIGIT: begin
               mag_in  = quo_ten;
               dig_in  = {digit, dig_ff[DIGITS*4-1:4]};
               iter_in = iter_ff - 1'b1;
            end
            OP_EMIT: begin
               if (!out_busy) begin
                  rsp_valid_in = 1'b1;
                  milli_in     = (MILLI_W'(centi_ff) <<< 3) + (MILLI_W'(centi_ff) <<< 1);
                  sign_in      = neg_ff ? ASCII_MINUS : ASCII_PLUS;
                  out_dig_in   = dig_ff;
                  out_flag_in  = flag_ff;
               end
            end
            default: ;
         endcase

         case (uc.cond)
            COND_ITER: begin
               pc_in = (iter_ff != '0) ? uc.target : pc_ff + 1'b1;
            end
            COND_SEARCH: begin
               pc_in = search_more ? uc.target : pc_ff + 1'b1;
            end
            COND_EMIT: begin
               if (out_busy) begin
                  pc_in = uc.target;
               end else begin
                  busy_in = 1'b0;
               end
            end
            default: begin
               pc_in = pc_ff + 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff  <= SAMPLE_COUNT_RST;
         table_base_ff    <= TABLE_BASE_RST;
         sample_sum_ff    <= '0;
         samples_taken_ff <= '0;
         busy_ff          <= 1'b0;
         pc_ff            <= S_DIV_MEAN;
         rsp_valid_ff     <= 1'b0;
      end else begin
         sample_count_ff  <= sample_count_in;
         table_base_ff    <= table_base_in;
         sample_sum_ff    <= sample_sum_in;
         samples_taken_ff <= samples_taken_in;
         busy_ff          <= busy_in;
         pc_ff            <= pc_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff     <= iter_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      v_ff        <= v_in;
      flag_ff     <= flag_in;
      k_ff        <= k_in;
      seg_ff      <= seg_in;
      flat_ff     <= flat_in;
      centi_ff    <= centi_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      dig_ff      <= dig_in;
      milli_ff    <= milli_in;
      sign_ff     <= sign_in;
      out_dig_ff  <= out_dig_in;
      out_flag_ff <= out_flag_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_temperature_milli   = milli_ff;
   assign rsp_sign_char           = sign_ff;
   assign rsp_digit_ten_thousands = ASCII_ZERO + CHAR_W'(out_dig_ff[15:12]);
   assign rsp_digit_thousands     = ASCII_ZERO + CHAR_W'(out_dig_ff[11:8]);
   assign rsp_digit_hundreds      = ASCII_ZERO + CHAR_W'(out_dig_ff[7:4]);
   assign rsp_digit_tens          = ASCII_ZERO + CHAR_W'(out_dig_ff[3:0]);
   // The temperature is ten times a centi-degree value, so its last digit is zero.
   assign rsp_digit_ones          = ASCII_ZERO;
   assign rsp_out_of_table        = out_flag_ff;

   // The step counter never leaves the program while it runs.
   `ASSERT_NEVER(a_pc_in_program, clock, reset, busy_ff && (pc_ff > S_EMIT), "step counter beyond program end")
   // A new result appears only from the emit step.
   `ASSERT_HOLDS(a_emit_source, clock, reset, $rose(rsp_valid_ff) |-> $past(busy_ff && (pc_ff == S_EMIT)), "result raised outside the emit step")
   // The mean of at most 14-bit sums fits 14 bits when it is clamped.
   `ASSERT_HOLDS(a_mean_width, clock, reset, busy_ff && (pc_ff == S_CLAMP) |-> (div_quo_ff[DIV_W-1:SUM_W] == '0), "mean wider than the sum")

endmodule

`default_nettype wire

// ===== verif/ntc_oversample_linearizer_tb.sv =====
// Self-checking testbench of the NTC oversampling linearizer: random and directed ADC words,
// a scoreboard that predicts each averaged temperature, randomized handshake pressure.
// Depends on ntcol_pkg and the ntc_oversample_linearizer RTL.
`timescale 1ns / 1ps

module ntc_oversample_linearizer_tb;

   import ntcol_pkg::*;

   // The block runs with its default sizes, so the predictor uses the same ones.
   localparam int POINTS      = (DEF_TABLE_ENTRIES > STORED_POINTS) ? STORED_POINTS
                                                                     : DEF_TABLE_ENTRIES;
   localparam int MAX_AVERAGE = DEF_MAX_SAMPLES;

   // Cycles to let pass before a register write. This outlasts a whole sequencer run
   // with the longest table walk, so it covers a word still being worked on.
   localparam int SETTLE_CYCLES = 200;

   // Cycles without any accepted word after which the run is declared hung.
   localparam int QUIET_LIMIT = 4000;

   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 56;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // One temperature reading as the result channel carries it. Digit 4 is the
   // ten-thousands place, digit 0 the ones place.
   typedef struct packed {
      logic [MILLI_W-1:0]            milli;
      logic [CHAR_W-1:0]             sign_char;
      logic [4:0][CHAR_W-1:0]        digits;
      logic                          out_of_table;
   } reading_type;

   // Mirrors the accumulator and the linearizer, and holds the readings that
   // the block still owes on its result channel.
   class ntc_reading_tracker;
      logic [CNT_W-1:0] count_reg;
      int               base_centi;
      logic [SUM_W-1:0] sum_acc;
      logic [TAKEN_W-1:0] words_in_sum;
      reading_type      expected_readings [$];
      int               errors;

      function new();
         count_reg    = SAMPLE_COUNT_RST;
         base_centi   = TABLE_BASE_RST;
         sum_acc      = '0;
         words_in_sum = '0;
         errors       = 0;
      endfunction

      function void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_SAMPLE_COUNT) begin
            count_reg = data[CNT_W-1:0];
         end else begin
            base_centi = int'($signed(data[BASE_W-1:0]));
         end
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      function bit group_empty();
         return words_in_sum == 0;
      endfunction

      // Clamps the mean to the table, finds its segment and interpolates in
      // hundredths of a degree, then formats the reading.
      function reading_type predict_temperature(int mean);
         reading_type r;
         int v, k, seg, lo, hi, frac, centi, milli, mag;
         bit clamped;
         clamped = 1'b0;
         v = mean;
         if (v < NTC_POINTS[0]) begin
            v = NTC_POINTS[0];
            clamped = 1'b1;
         end
         if (v > NTC_POINTS[POINTS-1]) begin
            v = NTC_POINTS[POINTS-1];
            clamped = 1'b1;
         end
         k = 0;
         while (k < POINTS - 1 && NTC_POINTS[k] < v) k++;
         seg  = (k > 0) ? k - 1 : 0;
         lo   = NTC_POINTS[seg];
         hi   = NTC_POINTS[seg+1];
         frac = (hi > lo) ? ((v - lo) * 100) / (hi - lo) : 0;
         centi = base_centi + 100 * seg + frac;
         if (centi > CENTI_MAX) centi = CENTI_MAX;
         if (centi < -CENTI_MAX) centi = -CENTI_MAX;
         milli = centi * 10;
         mag   = (milli < 0) ? -milli : milli;
         r.milli        = milli[MILLI_W-1:0];
         r.sign_char    = (milli < 0) ? ASCII_MINUS : ASCII_PLUS;
         r.digits[4]    = ASCII_ZERO + CHAR_W'((mag / 10000) % 10);
         r.digits[3]    = ASCII_ZERO + CHAR_W'((mag / 1000) % 10);
         r.digits[2]    = ASCII_ZERO + CHAR_W'((mag / 100) % 10);
         r.digits[1]    = ASCII_ZERO + CHAR_W'((mag / 10) % 10);
         r.digits[0]    = ASCII_ZERO + CHAR_W'(mag % 10);
         r.out_of_table = clamped;
         return r;
      endfunction

      function void note_sample(logic [ADC_W-1:0] adc);
         int limit_n;
         int mean;
         limit_n = (count_reg == 0) ? 1 : (count_reg > MAX_AVERAGE) ? MAX_AVERAGE
                                                                    : int'(count_reg);
         sum_acc      = sum_acc + SUM_W'(adc);
         words_in_sum = words_in_sum + 1'b1;
         if (words_in_sum < limit_n) return;
         mean         = int'(sum_acc) / limit_n;
         sum_acc      = '0;
         words_in_sum = '0;
         expected_readings.push_back(predict_temperature(mean));
      endfunction

      function void compare(string field, int want_v, int got_v);
         if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v,
                     got_v);
            errors++;
         end
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         string place [5];
         place = '{"digit_ones", "digit_tens", "digit_hundreds", "digit_thousands",
                   "digit_ten_thousands"};
         if (expected_readings.size() == 0) begin
            $display("%0t: result word with nothing expected, expected none, actual %0d",
                     $time, $signed(got.milli));
            errors++;
            return;
         end
         want = expected_readings.pop_front();
         compare("temperature_milli", $signed(want.milli), $signed(got.milli));
         compare("sign_char", want.sign_char, got.sign_char);
         for (int d = 0; d < 5; d++) compare(place[d], want.digits[d], got.digits[d]);
         compare("out_of_table", want.out_of_table, got.out_of_table);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [ADC_W-1:0] req_adc_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [MILLI_W-1:0] rsp_temperature_milli;
   logic [CHAR_W-1:0] rsp_sign_char;
   logic [CHAR_W-1:0] rsp_digit_ten_thousands;
   logic [CHAR_W-1:0] rsp_digit_thousands;
   logic [CHAR_W-1:0] rsp_digit_hundreds;
   logic [CHAR_W-1:0] rsp_digit_tens;
   logic [CHAR_W-1:0] rsp_digit_ones;
   logic rsp_out_of_table;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   idle_mode_type mode = IDLE_NONE;
   ntc_reading_tracker sb;

   ntc_oversample_linearizer #(
      .TABLE_ENTRIES(DEF_TABLE_ENTRIES),
      .MAX_SAMPLES  (DEF_MAX_SAMPLES)
   ) DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_adc_sample         (req_adc_sample),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_temperature_milli  (rsp_temperature_milli),
      .rsp_sign_char          (rsp_sign_char),
      .rsp_digit_ten_thousands(rsp_digit_ten_thousands),
      .rsp_digit_thousands    (rsp_digit_thousands),
      .rsp_digit_hundreds     (rsp_digit_hundreds),
      .rsp_digit_tens         (rsp_digit_tens),
      .rsp_digit_ones         (rsp_digit_ones),
      .rsp_out_of_table       (rsp_out_of_table),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   // 8 ns clock, 4 ns low then 4 ns high.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver stalls at random while the current mode asks for it. Stall
   // changes only at the falling edge, so the block sees it settled.
   always @(negedge clock) begin
      if (mode == IDLE_RECEIVER) begin
         rsp_stall <= ($urandom_range(0, 99) < 80);
      end else if (mode == IDLE_BOTH) begin
         rsp_stall <= ($urandom_range(0, 99) < 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every accepted result word is checked against the oldest expected reading.
   // Sampling right at the rising edge sees the values from before the edge.
   always @(posedge clock) begin : result_monitor
      reading_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.milli        = rsp_temperature_milli;
         got.sign_char    = rsp_sign_char;
         got.digits       = {rsp_digit_ten_thousands, rsp_digit_thousands,
                             rsp_digit_hundreds, rsp_digit_tens, rsp_digit_ones};
         got.out_of_table = rsp_out_of_table;
         sb.check_reading(got);
      end
   end

   // Hang detection: the run ends once nothing at all has been accepted on any
   // channel while the quiet count climbs to QUIET_LIMIT.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("ntc_oversample_linearizer_tb: errors");
      $finish;
   end

   // Offers one ADC word, after a random number of idle cycles when the mode
   // asks for sender gaps. Valid stays high from one word to the next when
   // there is no gap. Called and left at a falling edge.
   task automatic send_sample(input logic [ADC_W-1:0] adc);
      int gap_pct;
      gap_pct = (mode == IDLE_SENDER) ? 80 : (mode == IDLE_BOTH) ? 8 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= adc;
      do @(posedge clock); while (req_stall);
      sb.note_sample(adc);
      @(negedge clock);
   endtask

   // The sender holds off until every expected reading has come back.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(negedge clock);
   endtask

   // Writes both registers while the block is idle. A word that completes no
   // average produces nothing to wait for, so a fixed settle time follows the
   // drain to cover a sequencer run that may still be in progress.
   task automatic configure(input logic [CSR_DATA_W-1:0] count_word,
                            input logic [CSR_DATA_W-1:0] base_word);
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_SAMPLE_COUNT;
      csr_wdata <= count_word;
      do @(posedge clock); while (!csr_ready);
      sb.apply_csr(CSR_SAMPLE_COUNT, count_word);
      @(negedge clock);
      csr_index <= CSR_TABLE_BASE;
      csr_wdata <= base_word;
      do @(posedge clock); while (!csr_ready);
      sb.apply_csr(CSR_TABLE_BASE, base_word);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int level, jit;
      logic [CSR_DATA_W-1:0] count_word, base_word;
      logic [ADC_W-1:0] adc;

      sb = new();
      level          = 512;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_adc_sample = '0;
      rsp_stall      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_SAMPLE_COUNT;
      csr_wdata      = '0;

      // Synchronous reset, released at a falling edge.
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: ten words per average, base of -10.00 degrees. Alternating
      // all-ones and all-zeros words average to a table point exactly.
      for (int n = 0; n < 10; n++) send_sample(n[0] ? 10'h3FF : 10'h000);

      // One word per average, lowest base: the table ends, a word just inside one end and
      // one just outside the other, and both extremes of the converter range.
      configure(13'd1, 13'h1000);
      send_sample(10'd0);
      send_sample(10'd176);
      send_sample(10'd177);
      send_sample(10'd511);
      send_sample(10'd933);
      send_sample(10'd934);
      send_sample(10'h3FF);

      // A count of zero behaves as one. The highest base drives the reading past
      // five digits, so the centi value saturates.
      configure(13'd0, 13'd4095);
      send_sample(10'd933);
      send_sample(10'd850);

      // Count lowered while an average is half done: two words sit in the sum,
      // then the count drops to two, so the third word completes the average.
      configure(13'd4, 13'd0);
      send_sample(10'd300);
      send_sample(10'd300);
      configure(13'd2, 13'd0);
      send_sample(10'd300);

      // Random phases. Each average gets a level mostly inside the table, with
      // small jitter per word, so the means spread over every segment rather
      // than bunching near mid-scale. A few words are fully random noise.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         count_word = CSR_DATA_W'($urandom);
         base_word  = CSR_DATA_W'($urandom);
         case (p)
            0: begin
               count_word[CNT_W-1:0] = 5'd16;
               base_word             = 13'h1000;
            end
            1: begin
               count_word[CNT_W-1:0] = 5'd31;
               base_word             = 13'd4095;
            end
            2: count_word[CNT_W-1:0] = 5'd0;
            3: begin
               count_word[CNT_W-1:0] = CNT_W'($urandom_range(1, 12));
               base_word             = -13'sd4000;
            end
            4: begin
               count_word[CNT_W-1:0] = CNT_W'($urandom_range(1, 12));
               base_word             = 13'd4000;
            end
            5: count_word[CNT_W-1:0] = CNT_W'($urandom_range(17, 31));
            default: count_word[CNT_W-1:0] = CNT_W'($urandom_range(1, 12));
         endcase
         configure(count_word, base_word);
         mode = idle_mode_type'(p % 4);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (n == WORDS_PER_PHASE / 2) pause_until_drained();
            if (sb.group_empty()) begin
               if ($urandom_range(0, 9) == 0) begin
                  level = $urandom_range(0, 1) ? $urandom_range(0, 175)
                                               : $urandom_range(934, 1023);
               end else begin
                  level = $urandom_range(176, 933);
               end
            end
            if ($urandom_range(0, 6) == 0) begin
               adc = ADC_W'($urandom_range(0, 1023));
            end else begin
               jit = $urandom_range(0, 16);
               jit = level + jit - 8;
               if (jit < 0) jit = 0;
               if (jit > 1023) jit = 1023;
               adc = jit[ADC_W-1:0];
            end
            send_sample(adc);
         end
      end

      // Wind down: all readings in, then one more sequencer run of quiet time to
      // catch any stray result word.
      mode = IDLE_NONE;
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("ntc_oversample_linearizer_tb: clean");
      end else begin
         $display("ntc_oversample_linearizer_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ntcol_pkg.sv
hw/rtl/ntc_oversample_linearizer.sv
verif/ntc_oversample_linearizer_tb.sv
